/* src/mfh_pkg.sv */
// Shared types, codes and the term update tables of the mean-field Hamiltonian block.
// No dependencies; compiled first.
package mfh_pkg;

  localparam int FUNC_W  = 4;
  localparam int SITE_W  = 4;
  localparam int FIELD_W = 32;
  localparam int NS_W    = 5;
  localparam int CIDX_W  = 4;
  localparam int CDATA_W = 32;
  localparam int STEP_W  = 4;

  // item function codes
  localparam logic [FUNC_W-1:0] FN_WRITE_G  = 4'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR_H  = 4'd1;
  localparam logic [FUNC_W-1:0] FN_TRANSFER = 4'd2;
  localparam logic [FUNC_W-1:0] FN_ONSITE   = 4'd3;
  localparam logic [FUNC_W-1:0] FN_INTER    = 4'd4;
  localparam logic [FUNC_W-1:0] FN_HUND     = 4'd5;
  localparam logic [FUNC_W-1:0] FN_EXCHANGE = 4'd6;
  localparam logic [FUNC_W-1:0] FN_PAIRHOP  = 4'd7;
  localparam logic [FUNC_W-1:0] FN_FOUR     = 4'd8;
  localparam logic [FUNC_W-1:0] FN_READ_H   = 4'd9;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_SITE_COUNT = 4'd0;
  localparam logic [CIDX_W-1:0] CFG_FOCK       = 4'd1;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_EXEC, ST_G1, ST_G2, ST_MUL, ST_WR, ST_CLR, ST_RDH, ST_DONE
  } state_t;

  // matrix operands of a term
  typedef enum logic [2:0] {
    OP_U1, OP_D1, OP_U2, OP_D2, OP_I1, OP_I2, OP_I3, OP_I4
  } opnd_t;

  typedef enum logic [1:0] {
    MD_NORM,    // H += k * G[gr][gc]
    MD_CHARGE,  // H += k * (Re G[gr][gr] + Re G[gc][gc])
    MD_DIRECT   // H += k, unrounded
  } upd_mode_t;

  typedef struct packed {
    opnd_t     hr;
    opnd_t     hc;
    opnd_t     gr;
    opnd_t     gc;
    upd_mode_t mode;
    logic      neg;
  } upd_desc_t;

  function automatic upd_desc_t mk(opnd_t hr, opnd_t hc, opnd_t gr, opnd_t gc,
                                   upd_mode_t mode, logic neg);
    upd_desc_t d;
    d.hr = hr; d.hc = hc; d.gr = gr; d.gc = gc; d.mode = mode; d.neg = neg;
    return d;
  endfunction

  // one H update of a term, in the order they are applied
  function automatic upd_desc_t step_desc(logic [FUNC_W-1:0] func, logic [STEP_W-1:0] step);
    upd_desc_t d;
    d = mk(OP_I1, OP_I2, OP_I1, OP_I2, MD_NORM, 1'b0);
    case (func)
      FN_TRANSFER: d = mk(OP_I1, OP_I2, OP_I1, OP_I2, MD_DIRECT, 1'b1);
      FN_ONSITE: begin
        case (step)
          4'd0:    d = mk(OP_U1, OP_U1, OP_D1, OP_D1, MD_NORM, 1'b0);
          4'd1:    d = mk(OP_D1, OP_D1, OP_U1, OP_U1, MD_NORM, 1'b0);
          4'd2:    d = mk(OP_U1, OP_D1, OP_D1, OP_U1, MD_NORM, 1'b1);
          default: d = mk(OP_D1, OP_U1, OP_U1, OP_D1, MD_NORM, 1'b1);
        endcase
      end
      FN_INTER: begin
        case (step)
          4'd0:    d = mk(OP_U1, OP_U1, OP_U2, OP_D2, MD_CHARGE, 1'b0);
          4'd1:    d = mk(OP_D1, OP_D1, OP_U2, OP_D2, MD_CHARGE, 1'b0);
          4'd2:    d = mk(OP_U2, OP_U2, OP_U1, OP_D1, MD_CHARGE, 1'b0);
          4'd3:    d = mk(OP_D2, OP_D2, OP_U1, OP_D1, MD_CHARGE, 1'b0);
          4'd4:    d = mk(OP_U1, OP_U2, OP_U2, OP_U1, MD_NORM, 1'b1);
          4'd5:    d = mk(OP_U2, OP_U1, OP_U1, OP_U2, MD_NORM, 1'b1);
          4'd6:    d = mk(OP_D1, OP_D2, OP_D2, OP_D1, MD_NORM, 1'b1);
          4'd7:    d = mk(OP_D2, OP_D1, OP_D1, OP_D2, MD_NORM, 1'b1);
          4'd8:    d = mk(OP_U1, OP_D2, OP_D2, OP_U1, MD_NORM, 1'b1);
          4'd9:    d = mk(OP_D2, OP_U1, OP_U1, OP_D2, MD_NORM, 1'b1);
          4'd10:   d = mk(OP_U2, OP_D1, OP_D1, OP_U2, MD_NORM, 1'b1);
          default: d = mk(OP_D1, OP_U2, OP_U2, OP_D1, MD_NORM, 1'b1);
        endcase
      end
      FN_HUND: begin
        case (step)
          4'd0:    d = mk(OP_U1, OP_U1, OP_U2, OP_U2, MD_NORM, 1'b1);
          4'd1:    d = mk(OP_D1, OP_D1, OP_D2, OP_D2, MD_NORM, 1'b1);
          4'd2:    d = mk(OP_U2, OP_U2, OP_U1, OP_U1, MD_NORM, 1'b1);
          4'd3:    d = mk(OP_D2, OP_D2, OP_D1, OP_D1, MD_NORM, 1'b1);
          4'd4:    d = mk(OP_U1, OP_U2, OP_U2, OP_U1, MD_NORM, 1'b0);
          4'd5:    d = mk(OP_U2, OP_U1, OP_U1, OP_U2, MD_NORM, 1'b0);
          4'd6:    d = mk(OP_D1, OP_D2, OP_D2, OP_D1, MD_NORM, 1'b0);
          default: d = mk(OP_D2, OP_D1, OP_D1, OP_D2, MD_NORM, 1'b0);
        endcase
      end
      FN_EXCHANGE: begin
        case (step)
          4'd0:    d = mk(OP_U1, OP_U2, OP_D2, OP_D1, MD_NORM, 1'b0);
          4'd1:    d = mk(OP_D2, OP_D1, OP_U1, OP_U2, MD_NORM, 1'b0);
          4'd2:    d = mk(OP_D1, OP_D2, OP_U2, OP_U1, MD_NORM, 1'b0);
          4'd3:    d = mk(OP_U2, OP_U1, OP_D1, OP_D2, MD_NORM, 1'b0);
          4'd4:    d = mk(OP_U1, OP_D1, OP_D2, OP_U2, MD_NORM, 1'b1);
          4'd5:    d = mk(OP_U2, OP_D2, OP_D1, OP_U1, MD_NORM, 1'b1);
          4'd6:    d = mk(OP_D1, OP_U1, OP_U2, OP_D2, MD_NORM, 1'b1);
          default: d = mk(OP_D2, OP_U2, OP_U1, OP_D1, MD_NORM, 1'b1);
        endcase
      end
      FN_PAIRHOP: begin
        case (step)
          4'd0:    d = mk(OP_U1, OP_U2, OP_D1, OP_D2, MD_NORM, 1'b0);
          4'd1:    d = mk(OP_D1, OP_D2, OP_U1, OP_U2, MD_NORM, 1'b0);
          4'd2:    d = mk(OP_U1, OP_D2, OP_D1, OP_U2, MD_NORM, 1'b1);
          default: d = mk(OP_D1, OP_U2, OP_U1, OP_D2, MD_NORM, 1'b1);
        endcase
      end
      FN_FOUR: begin
        case (step)
          4'd0:    d = mk(OP_I1, OP_I2, OP_I3, OP_I4, MD_NORM, 1'b0);
          4'd1:    d = mk(OP_I3, OP_I4, OP_I1, OP_I2, MD_NORM, 1'b0);
          4'd2:    d = mk(OP_I1, OP_I4, OP_I2, OP_I3, MD_NORM, 1'b1);
          4'd3:    d = mk(OP_I2, OP_I3, OP_I1, OP_I4, MD_NORM, 1'b1);
          default: d = mk(OP_I1, OP_I4, OP_I1, OP_I4, MD_DIRECT, 1'b0);
        endcase
      end
      default: d = mk(OP_I1, OP_I2, OP_I1, OP_I2, MD_NORM, 1'b0);
    endcase
    return d;
  endfunction

endpackage

/* src/mfh_if.sv */
// Valid/ready channel interfaces of the mean-field Hamiltonian block.
// Depends on mfh_pkg for the field widths.
interface mfh_in_if;
  logic                            valid;
  logic                            ready;
  logic [mfh_pkg::FUNC_W-1:0]      func;
  logic [mfh_pkg::SITE_W-1:0]      site_a;
  logic                            spin_a;
  logic [mfh_pkg::SITE_W-1:0]      site_b;
  logic                            spin_b;
  logic [mfh_pkg::SITE_W-1:0]      site_c;
  logic                            spin_c;
  logic [mfh_pkg::SITE_W-1:0]      site_d;
  logic                            spin_d;
  logic signed [mfh_pkg::FIELD_W-1:0] value_re;
  logic signed [mfh_pkg::FIELD_W-1:0] value_im;

  modport source (output valid, func, site_a, spin_a, site_b, spin_b, site_c, spin_c,
                  site_d, spin_d, value_re, value_im, input ready);
  modport sink   (input valid, func, site_a, spin_a, site_b, spin_b, site_c, spin_c,
                  site_d, spin_d, value_re, value_im, output ready);
endinterface

interface mfh_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mfh_pkg::FIELD_W-1:0] ham_re;
  logic signed [mfh_pkg::FIELD_W-1:0] ham_im;
  logic                               status;

  modport source (output valid, ham_re, ham_im, status, input ready);
  modport sink   (input valid, ham_re, ham_im, status, output ready);
endinterface

interface mfh_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mfh_pkg::CIDX_W-1:0]       index;
  logic [mfh_pkg::CDATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/mean_field_hamiltonian_accumulate.sv */
// Mean-field Hamiltonian builder: H and G stores, term sequencer and complex MAC datapath.
// Depends on mfh_pkg and the channel interfaces in mfh_if.sv.
//
// One transaction in gives exactly one result out. After reset both stores are swept to zero,
// one entry a cycle, over all 2^(2*ceil(log2(2*MAX_SITES))) entries (1024 at the default),
// during which no item is taken; a clear-H item sweeps the H store the same way. A term item
// walks its update list through the H and G memories, each with one read and one write port;
// every H update passes the states G read, second G read plus H read, multiply and
// round-add-write, and an inter-site term with Fock terms on has up to twelve updates.
// Items are handled one at a time; the result register lets the next item in while a
// result waits to be taken.
module mean_field_hamiltonian_accumulate #(
  parameter int MAX_SITES  = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  mfh_in_if.sink          in_ch,
  mfh_out_if.source       out_ch,
  mfh_cfg_if.sink         cfg_ch
);
  import mfh_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int IW    = $clog2(2 * MAX_SITES);
  localparam int ADW   = 2 * IW;
  localparam int DEPTH = 1 << ADW;
  localparam int KW    = FIELD_W + 1;        // coefficient, exact after negation
  localparam int PW    = KW + VB;            // product width
  localparam int RW    = PW - 16;            // rounded product
  localparam int SUMW  = RW + 2;
  localparam int NS_RST = (MAX_SITES < 16) ? MAX_SITES : 16;
  localparam logic signed [SUMW-1:0] VMAX_S = {{(SUMW-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [SUMW-1:0] VMIN_S = ~VMAX_S;
  localparam logic [ADW-1:0] ADDR_LAST = {ADW{1'b1}};

  function automatic logic signed [VB-1:0] sat(logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] r;
    r = v;
    if (v > VMAX_S) r = VMAX_S;
    else if (v < VMIN_S) r = VMIN_S;
    return r[VB-1:0];
  endfunction

  function automatic logic [IW-1:0] mat_idx(logic [SITE_W-1:0] site, logic spin,
                                            logic [NS_W-1:0] ns);
    logic [NS_W+1:0] t;
    t = {{(NS_W+2-SITE_W){1'b0}}, site} + (spin ? {2'b00, ns} : '0);
    return t[IW-1:0];
  endfunction

  // configuration
  logic [NS_W-1:0] ns_r;
  logic            fock_r;

  // item registers
  state_t state_r, state_nxt;
  logic [FUNC_W-1:0]         func_r;
  logic [3:0][SITE_W-1:0]    site_r;
  logic [3:0]                spin_r;
  logic signed [FIELD_W-1:0] vr_r, vi_r;
  logic                      stat_r;
  logic [STEP_W-1:0]         step_r, nsteps;
  logic [ADW-1:0]            clr_cnt_r;
  logic signed [FIELD_W-1:0] res_re_r, res_im_r;

  // memories
  logic [2*VB-1:0] h_mem [DEPTH];
  logic [2*VB-1:0] g_mem [DEPTH];
  logic            h_we, g_we;
  logic [ADW-1:0]  h_waddr, h_raddr, g_waddr, g_raddr;
  logic [2*VB-1:0] h_wdata, g_wdata, h_rdata_r, g_rdata_r;

  // datapath
  logic [2*VB-1:0]           g1_r, h_cur_r;
  logic signed [PW-1:0]      p_r [4];
  logic signed [PW-1:0]      mx [4];
  logic signed [KW-1:0]      kr, ki, mk_a [4];
  logic signed [VB-1:0]      mk_b [4];
  logic signed [RW-1:0]      rp [4];
  logic signed [PW-1:0]      pr_t [4];
  logic signed [RW:0]        dre, dim;
  logic signed [SUMW-1:0]    sum_re, sum_im;
  logic signed [VB-1:0]      new_re, new_im;

  // output register
  logic                      out_valid_r, out_st_r;
  logic signed [FIELD_W-1:0] out_re_r, out_im_r;

  logic in_acc, in_stat;
  logic [7:0][IW-1:0] opv;
  upd_desc_t desc;
  logic [IW-1:0] hr_i, hc_i, gr_i, gc_i;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.ham_re = out_re_r;
  assign out_ch.ham_im = out_im_r;
  assign out_ch.status = out_st_r;

  // site range check on the incoming transaction
  always_comb begin
    logic [NS_W-1:0] sa, sb, sc, sd;
    sa = {1'b0, in_ch.site_a};
    sb = {1'b0, in_ch.site_b};
    sc = {1'b0, in_ch.site_c};
    sd = {1'b0, in_ch.site_d};
    in_stat = 1'b0;
    if (in_ch.func == FN_ONSITE) begin
      in_stat = (sa >= ns_r);
    end else if (in_ch.func == FN_FOUR) begin
      in_stat = (sa >= ns_r) || (sb >= ns_r) || (sc >= ns_r) || (sd >= ns_r);
    end else if (in_ch.func inside {FN_WRITE_G, FN_TRANSFER, FN_READ_H,
                                    [FN_INTER:FN_PAIRHOP]}) begin
      in_stat = (sa >= ns_r) || (sb >= ns_r);
    end
  end

  // matrix operands of the current item
  always_comb begin
    opv[OP_U1] = mat_idx(site_r[0], 1'b0, ns_r);
    opv[OP_D1] = mat_idx(site_r[0], 1'b1, ns_r);
    opv[OP_U2] = mat_idx(site_r[1], 1'b0, ns_r);
    opv[OP_D2] = mat_idx(site_r[1], 1'b1, ns_r);
    opv[OP_I1] = mat_idx(site_r[0], spin_r[0], ns_r);
    opv[OP_I2] = mat_idx(site_r[1], spin_r[1], ns_r);
    opv[OP_I3] = mat_idx(site_r[2], spin_r[2], ns_r);
    opv[OP_I4] = mat_idx(site_r[3], spin_r[3], ns_r);
  end

  assign desc = step_desc(func_r, step_r);
  assign hr_i = opv[desc.hr];
  assign hc_i = opv[desc.hc];
  assign gr_i = opv[desc.gr];
  assign gc_i = opv[desc.gc];

  always_comb begin
    case (func_r)
      FN_TRANSFER: nsteps = 4'd1;
      FN_ONSITE:   nsteps = 4'd4;
      FN_INTER:    nsteps = fock_r ? 4'd12 : 4'd4;
      FN_HUND:     nsteps = fock_r ? 4'd8 : 4'd4;
      FN_EXCHANGE: nsteps = fock_r ? 4'd8 : 4'd0;
      FN_PAIRHOP:  nsteps = fock_r ? 4'd4 : 4'd0;
      FN_FOUR:     nsteps = !fock_r ? 4'd0 : (opv[OP_I2] == opv[OP_I3]) ? 4'd5 : 4'd4;
      default:     nsteps = 4'd0;
    endcase
  end

  // coefficient and multiplier operands
  always_comb begin
    kr = desc.neg ? -KW'(vr_r) : KW'(vr_r);
    ki = desc.neg ? -KW'(vi_r) : KW'(vi_r);
    if (desc.mode == MD_CHARGE) begin
      mk_a[0] = kr; mk_b[0] = signed'(g1_r[VB-1:0]);
      mk_a[1] = kr; mk_b[1] = signed'(g_rdata_r[VB-1:0]);
      mk_a[2] = ki; mk_b[2] = signed'(g1_r[VB-1:0]);
      mk_a[3] = ki; mk_b[3] = signed'(g_rdata_r[VB-1:0]);
    end else begin
      mk_a[0] = kr; mk_b[0] = signed'(g1_r[VB-1:0]);
      mk_a[1] = ki; mk_b[1] = signed'(g1_r[2*VB-1:VB]);
      mk_a[2] = kr; mk_b[2] = signed'(g1_r[2*VB-1:VB]);
      mk_a[3] = ki; mk_b[3] = signed'(g1_r[VB-1:0]);
    end
    for (int i = 0; i < 4; i++) begin
      mx[i] = PW'(mk_a[i]) * PW'(mk_b[i]);
    end
  end

  // round half up, sum, accumulate with saturation
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pr_t[i] = p_r[i] + PW'(32768);
      rp[i]   = pr_t[i][PW-1:16];
    end
    case (desc.mode)
      MD_DIRECT: begin
        dre = (RW+1)'(kr);
        dim = (RW+1)'(ki);
      end
      MD_CHARGE: begin
        dre = (RW+1)'(rp[0]) + (RW+1)'(rp[1]);
        dim = (RW+1)'(rp[2]) + (RW+1)'(rp[3]);
      end
      default: begin
        dre = (RW+1)'(rp[0]) - (RW+1)'(rp[1]);
        dim = (RW+1)'(rp[2]) + (RW+1)'(rp[3]);
      end
    endcase
    sum_re = SUMW'(signed'(h_cur_r[VB-1:0])) + SUMW'(dre);
    sum_im = SUMW'(signed'(h_cur_r[2*VB-1:VB])) + SUMW'(dim);
    new_re = sat(sum_re);
    new_im = sat(sum_im);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_INIT;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    g_we    = 1'b0;
    g_waddr = {opv[OP_I1], opv[OP_I2]};
    g_wdata = {sat(SUMW'(vi_r)), sat(SUMW'(vr_r))};
    g_raddr = (desc.mode == MD_CHARGE) ? {gr_i, gr_i} : {gr_i, gc_i};
    h_we    = 1'b0;
    h_waddr = {hr_i, hc_i};
    h_wdata = {new_im, new_re};
    h_raddr = {hr_i, hc_i};
    case (state_r)
      ST_INIT: begin
        g_we = 1'b1; h_we = 1'b1;
        g_waddr = clr_cnt_r; h_waddr = clr_cnt_r;
        g_wdata = '0; h_wdata = '0;
        if (clr_cnt_r == ADDR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (stat_r) begin
          state_nxt = ST_DONE;
        end else begin
          case (func_r)
            FN_WRITE_G: begin
              g_we = 1'b1;
              state_nxt = ST_DONE;
            end
            FN_CLEAR_H: state_nxt = ST_CLR;
            FN_READ_H: begin
              h_raddr = {opv[OP_I1], opv[OP_I2]};
              state_nxt = ST_RDH;
            end
            default: begin
              if (func_r inside {[FN_TRANSFER:FN_FOUR]} && nsteps != '0) state_nxt = ST_G1;
              else state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_G1: state_nxt = ST_G2;
      ST_G2: begin
        g_raddr = {gc_i, gc_i};
        state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_WR;
      ST_WR: begin
        h_we = 1'b1;
        state_nxt = (step_r == nsteps - 4'd1) ? ST_DONE : ST_G1;
      end
      ST_CLR: begin
        h_we = 1'b1;
        h_waddr = clr_cnt_r;
        h_wdata = '0;
        if (clr_cnt_r == ADDR_LAST) state_nxt = ST_DONE;
      end
      ST_RDH: state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (h_we) h_mem[h_waddr] <= h_wdata;
    h_rdata_r <= h_mem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (g_we) g_mem[g_waddr] <= g_wdata;
    g_rdata_r <= g_mem[g_raddr];
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r        <= NS_W'(NS_RST);
      fock_r      <= 1'b1;
      clr_cnt_r   <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == CFG_SITE_COUNT) begin
          if (cfg_ch.data[NS_W-1:0] == '0) ns_r <= NS_W'(1);
          else if (int'(cfg_ch.data[NS_W-1:0]) > MAX_SITES) ns_r <= NS_W'(MAX_SITES);
          else ns_r <= cfg_ch.data[NS_W-1:0];
        end else if (cfg_ch.index == CFG_FOCK) begin
          fock_r <= cfg_ch.data[0];
        end
      end
      if (in_acc) begin
        clr_cnt_r <= '0;
        step_r    <= '0;
      end else if (state_r == ST_INIT || state_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + ADW'(1);
      end else if (state_r == ST_WR) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= in_ch.func;
      site_r   <= {in_ch.site_d, in_ch.site_c, in_ch.site_b, in_ch.site_a};
      spin_r   <= {in_ch.spin_d, in_ch.spin_c, in_ch.spin_b, in_ch.spin_a};
      vr_r     <= in_ch.value_re;
      vi_r     <= in_ch.value_im;
      stat_r   <= in_stat;
      res_re_r <= '0;
      res_im_r <= '0;
    end
    if (state_r == ST_G2) g1_r <= g_rdata_r;
    if (state_r == ST_MUL) begin
      for (int i = 0; i < 4; i++) p_r[i] <= mx[i];
      h_cur_r <= h_rdata_r;
    end
    if (state_r == ST_RDH) begin
      res_re_r <= FIELD_W'(signed'(h_rdata_r[VB-1:0]));
      res_im_r <= FIELD_W'(signed'(h_rdata_r[2*VB-1:VB]));
    end
    if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) begin
      out_re_r <= res_re_r;
      out_im_r <= res_im_r;
      out_st_r <= stat_r;
    end
  end

  // checks
  a_init_after_reset: assert property (@(posedge clk) !rst_n |=> state_r == ST_INIT)
    else $error("no clearing sweep after reset");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR |-> step_r < nsteps)
    else $error("update step beyond the term's list");

  a_g_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    g_we |-> (state_r == ST_INIT || (state_r == ST_EXEC && func_r == FN_WRITE_G && !stat_r)))
    else $error("G written outside a G write");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r) |-> (out_re_r == '0 && out_im_r == '0))
    else $error("ignored transaction returned data");

  a_h_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
    h_we |-> !in_ch.ready)
    else $error("H written while idle");

endmodule
